FILE: hw/rtl/rse_pkg.sv
`default_nettype none

package rse_pkg;

  // Field polynomial x^8 + x^4 + x^3 + x^2 + 1 and the step between generator roots.
  localparam logic [8:0] GF_POLY      = 9'h11D;
  localparam logic [7:0] GF_ROOT_STEP = 8'h02;

  // Parity length after reset.
  localparam logic [4:0] ECC_LEN_RESET = 5'd10;

  // Register file: one register, selected by address bit 2.
  localparam int   ADDR_W         = 3;
  localparam logic REG_ECC_LENGTH = 1'b0;

  // Number of parity snapshots the front may run ahead of the back.
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    GEN_LOAD,
    GEN_RUN,
    GEN_DONE
  } gen_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // GF(256) product, most significant bit of b first.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] acc;
    acc = 9'd0;
    for (int bit_i = 7; bit_i >= 0; bit_i--) begin
      acc = {acc[7:0], 1'b0};
      if (acc[8]) begin
        acc = acc ^ GF_POLY;
      end
      if (b[bit_i]) begin
        acc = acc ^ {1'b0, a};
      end
    end
    return acc[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rse_gen.sv
`default_nettype none

module rse_gen #(
  parameter int MAX_ECC_LEN = 30,
  parameter int LEN_W       = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     restart,
  input  wire logic [LEN_W-1:0]         len_act,
  output logic                          busy,
  output logic [MAX_ECC_LEN*8-1:0]      coef
);

  rse_pkg::gen_state_t state, state_next;

  logic [7:0]       coef_r    [MAX_ECC_LEN];
  logic [7:0]       coef_step [MAX_ECC_LEN];
  logic [7:0]       root;
  logic [LEN_W-1:0] cnt;

  // One multiply-by-root step of the product (x - root) applied to every coefficient.
  always_comb begin
    for (int j = 0; j < MAX_ECC_LEN; j++) begin
      coef_step[j] = rse_pkg::gf_mul(coef_r[j], root);
      if (j + 1 < MAX_ECC_LEN) begin
        coef_step[j] = coef_step[j] ^ coef_r[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rse_pkg::GEN_LOAD;
    end else if (restart) begin
      state <= rse_pkg::GEN_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      rse_pkg::GEN_LOAD: begin
        state_next = rse_pkg::GEN_RUN;
      end
      rse_pkg::GEN_RUN: begin
        if (cnt == len_act - LEN_W'(1)) begin
          state_next = rse_pkg::GEN_DONE;
        end
      end
      rse_pkg::GEN_DONE: begin
        busy = 1'b0;
      end
      default: begin
        state_next = rse_pkg::GEN_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      rse_pkg::GEN_LOAD: begin
        for (int j = 0; j < MAX_ECC_LEN; j++) begin
          coef_r[j] <= (LEN_W'(j) == len_act - LEN_W'(1)) ? 8'd1 : 8'd0;
        end
        root <= 8'd1;
        cnt  <= '0;
      end
      rse_pkg::GEN_RUN: begin
        for (int j = 0; j < MAX_ECC_LEN; j++) begin
          coef_r[j] <= coef_step[j];
        end
        root <= rse_pkg::gf_mul(root, rse_pkg::GF_ROOT_STEP);
        cnt  <= cnt + LEN_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < MAX_ECC_LEN; j++) begin
      coef[j*8 +: 8] = coef_r[j];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rse_front.sv
`default_nettype none

module rse_front #(
  parameter int MAX_ECC_LEN = 30
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire logic                        gen_busy,
  input  wire logic [MAX_ECC_LEN*8-1:0]    coef,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        block_end,
  input  wire rse_pkg::q_status_t          q_stat,
  output logic                             push,
  output logic [MAX_ECC_LEN*8-1:0]         push_data
);

  logic [7:0] rem      [MAX_ECC_LEN];
  logic [7:0] rem_next [MAX_ECC_LEN];
  logic [7:0] factor;
  logic       accept;

  assign in_stall = gen_busy || q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && block_end;
  assign factor   = data_byte ^ rem[0];

  // Entries above the active length stay zero, as do their coefficients, so the
  // shift can run over the whole register whatever the length.
  always_comb begin
    for (int i = 0; i < MAX_ECC_LEN; i++) begin
      rem_next[i] = rse_pkg::gf_mul(coef[i*8 +: 8], factor);
      if (i + 1 < MAX_ECC_LEN) begin
        rem_next[i] = rem_next[i] ^ rem[i+1];
      end
      push_data[i*8 +: 8] = rem_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < MAX_ECC_LEN; i++) begin
        rem[i] <= 8'd0;
      end
    end else if (accept) begin
      for (int i = 0; i < MAX_ECC_LEN; i++) begin
        rem[i] <= block_end ? 8'd0 : rem_next[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rse_queue.sv
`default_nettype none

module rse_queue #(
  parameter int WIDTH = 240
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  push_data,
  input  wire logic              pop,
  output logic [WIDTH-1:0]       pop_data,
  output rse_pkg::q_status_t     q_stat
);

  localparam int AW = (rse_pkg::Q_DEPTH > 1) ? $clog2(rse_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(rse_pkg::Q_DEPTH + 1);

  logic [WIDTH-1:0] entry [rse_pkg::Q_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign pop_data     = entry[rd_ptr];
  assign q_stat.full  = (count == CW'(rse_pkg::Q_DEPTH));
  assign q_stat.empty = (count == CW'(0));

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(rse_pkg::Q_DEPTH - 1)) ? AW'(0) : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(rse_pkg::Q_DEPTH - 1)) ? AW'(0) : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rse_back.sv
`default_nettype none

module rse_back #(
  parameter int MAX_ECC_LEN = 30,
  parameter int LEN_W       = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [LEN_W-1:0]            len_act,
  input  wire rse_pkg::q_status_t          q_stat,
  output logic                             pop,
  input  wire logic [MAX_ECC_LEN*8-1:0]    q_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       ecc_byte,
  output logic                             ecc_last
);

  logic [MAX_ECC_LEN*8-1:0] sreg;
  logic [LEN_W-1:0]         rem_cnt;
  logic                     load_out;
  logic                     emit;

  assign load_out = !out_valid || !out_stall;
  assign emit     = load_out && (rem_cnt != LEN_W'(0));
  assign pop      = !q_stat.empty &&
                    ((rem_cnt == LEN_W'(0)) || ((rem_cnt == LEN_W'(1)) && emit));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_cnt <= '0;
    end else if (pop) begin
      rem_cnt <= len_act;
    end else if (emit) begin
      rem_cnt <= rem_cnt - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sreg <= q_data;
    end else if (emit) begin
      sreg <= sreg >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ecc_byte <= sreg[7:0];
      ecc_last <= (rem_cnt == LEN_W'(1));
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/reed_solomon_ecc_encoder.sv
// A block-end item's remainder goes through the queue and the back's shift register to the
// output register. Throughput: one data item per cycle while the two-entry parity queue
// has room and the generator is idle; a block emits one parity item per cycle unless the
// output stalls, as many as the active length. Reset (synchronous, active high) sets
// ecc_length to 10, clears the remainder and rebuilds the generator, stalling the input.
// Each write of ecc_length rebuilds the generator the same way and drops a partial block.
`default_nettype none

module reed_solomon_ecc_encoder #(
  parameter int MAX_ECC_LEN = 30
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rse_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Data items in
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       block_end,
  // Parity items out
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      ecc_byte,
  output logic                            ecc_last
);

  // Width that holds any active length from 1 up to MAX_ECC_LEN.
  localparam int LEN_W = $clog2(MAX_ECC_LEN + 1);
  localparam int VEC_W = MAX_ECC_LEN * 8;

  logic [4:0]         ecc_length;
  logic [LEN_W-1:0]   len_act;
  logic               cfg_wr;
  logic               gen_busy;
  logic [VEC_W-1:0]   coef;
  logic               q_push;
  logic               q_pop;
  logic [VEC_W-1:0]   q_push_data;
  logic [VEC_W-1:0]   q_pop_data;
  rse_pkg::q_status_t q_stat;

  // The register is written at the access phase of a write. Address bit 2 selects the
  // register; a write to any other register slot is dropped.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == rse_pkg::REG_ECC_LENGTH);
  assign prdata = (paddr[2] == rse_pkg::REG_ECC_LENGTH) ? {27'd0, ecc_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ecc_length <= rse_pkg::ECC_LEN_RESET;
    end else if (cfg_wr) begin
      ecc_length <= pwdata[4:0];
    end
  end

  // A length of zero behaves as one, and a length beyond the storage saturates.
  always_comb begin
    if (ecc_length == 5'd0) begin
      len_act = LEN_W'(1);
    end else if (int'(ecc_length) > MAX_ECC_LEN) begin
      len_act = LEN_W'(MAX_ECC_LEN);
    end else begin
      len_act = LEN_W'(ecc_length);
    end
  end

  // The generator is built by multiplying in one root per cycle, all coefficients at once.
  rse_gen #(
    .MAX_ECC_LEN (MAX_ECC_LEN),
    .LEN_W       (LEN_W)
  ) u_gen (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .len_act (len_act),
    .busy    (gen_busy),
    .coef    (coef)
  );

  // The front takes one data item per cycle while not stalled and updates the whole
  // remainder in parallel; at a block end it hands the finished remainder to the queue.
  rse_front #(
    .MAX_ECC_LEN (MAX_ECC_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_wr),
    .gen_busy  (gen_busy),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .block_end (block_end),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // The queue holds finished remainders so that short blocks can keep arriving while
  // the parity of earlier blocks is still being sent.
  rse_queue #(
    .WIDTH (VEC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .q_stat    (q_stat)
  );

  // Unless stalled, the back shifts a remainder one byte per cycle to a registered output.
  rse_back #(
    .MAX_ECC_LEN (MAX_ECC_LEN),
    .LEN_W       (LEN_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .len_act   (len_act),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .q_data    (q_pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ecc_byte  (ecc_byte),
    .ecc_last  (ecc_last)
  );

`ifndef NO_ASSERTIONS
  // No item may enter while the generator coefficients are being rebuilt.
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    gen_busy |-> in_stall)
    else $error("item accepted during generator build");

  // A register write always starts a rebuild.
  a_write_rebuilds: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> gen_busy)
    else $error("generator not rebuilt after length write");

  // The front never pushes a remainder into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("parity queue overflow");

  // The back never takes a remainder from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_stat.empty))
    else $error("parity queue underflow");
`endif

endmodule

`default_nettype wire

FILE: tb/rs_parity_checker.sv
// Watches both channels and the register port of the encoder, keeps its own
// copy of the generator and the remainder, and checks every parity item.
module rs_parity_checker #(
  parameter int MAX_ECC_LEN = 30
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rse_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  input  wire logic                       pready,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       block_end,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [7:0]                 ecc_byte,
  input  wire logic                       ecc_last,
  output int                              pending,
  output int                              mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  // Address bit that selects the register.
  localparam int REG_SEL_BIT = 2;

  typedef struct packed {
    logic [7:0] ecc_byte;
    logic       ecc_last;
  } parity_t;

  logic [4:0] ecc_length_reg;
  logic [7:0] gen_poly [MAX_ECC_LEN];
  logic [7:0] remainder_reg [MAX_ECC_LEN];
  parity_t    parity_due [$];

  // Shift-and-add product in GF(256), least significant bit of b first.
  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] x;
    prod = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        prod = prod ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ rse_pkg::GF_POLY[7:0]) : {x[6:0], 1'b0};
    end
    return prod;
  endfunction

  // Zero is taken as one and anything beyond the register depth saturates.
  function automatic int active_span();
    int n;
    n = ecc_length_reg;
    if (n < 1) begin
      n = 1;
    end
    if (n > MAX_ECC_LEN) begin
      n = MAX_ECC_LEN;
    end
    return n;
  endfunction

  function automatic void clear_remainder();
    foreach (remainder_reg[k]) begin
      remainder_reg[k] = 8'h00;
    end
  endfunction

  // Multiplies out (x - 1)(x - 2)(x - 4)... one root at a time.
  function automatic void form_generator();
    int n;
    logic [7:0] root;
    n = active_span();
    root = 8'h01;
    foreach (gen_poly[k]) begin
      gen_poly[k] = 8'h00;
    end
    gen_poly[n-1] = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        gen_poly[j] = gf_times(gen_poly[j], root);
        if (j + 1 < n) begin
          gen_poly[j] = gen_poly[j] ^ gen_poly[j+1];
        end
      end
      root = gf_times(root, rse_pkg::GF_ROOT_STEP);
    end
  endfunction

  function automatic void absorb_byte(input logic [7:0] d, input logic is_end);
    int n;
    logic [7:0] factor;
    parity_t p;
    n = active_span();
    factor = d ^ remainder_reg[0];
    for (int i = 0; i + 1 < n; i++) begin
      remainder_reg[i] = remainder_reg[i+1];
    end
    remainder_reg[n-1] = 8'h00;
    for (int i = 0; i < n; i++) begin
      remainder_reg[i] = remainder_reg[i] ^ gf_times(gen_poly[i], factor);
    end
    if (is_end) begin
      for (int i = 0; i < n; i++) begin
        p.ecc_byte = remainder_reg[i];
        p.ecc_last = (i == n - 1);
        parity_due = {parity_due, p};
      end
      clear_remainder();
    end
  endfunction

  always @(posedge clk) begin : watch
    parity_t due;
    if (rst) begin
      ecc_length_reg = rse_pkg::ECC_LEN_RESET;
      clear_remainder();
      form_generator();
      parity_due.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parity_due.size() == 0) begin
          $error("parity item with none due: ecc_byte %02h, ecc_last %0b", ecc_byte, ecc_last);
          mismatches++;
        end else begin
          due = parity_due.pop_front();
          if (ecc_byte !== due.ecc_byte) begin
            $error("ecc_byte: expected %02h, got %02h", due.ecc_byte, ecc_byte);
            mismatches++;
          end
          if (ecc_last !== due.ecc_last) begin
            $error("ecc_last: expected %0b, got %0b", due.ecc_last, ecc_last);
            mismatches++;
          end
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr[REG_SEL_BIT] == rse_pkg::REG_ECC_LENGTH) begin
        ecc_length_reg = pwdata[4:0];
        clear_remainder();
        form_generator();
      end
      if (in_valid && !in_stall) begin
        absorb_byte(data_byte, block_end);
      end
    end
    pending = parity_due.size();
  end

endmodule

FILE: tb/reed_solomon_ecc_encoder_tb.sv
// Top level of the encoder testbench. It makes the clock, the reset, the data
// items, the register writes and the back-pressure on the parity channel, and
// it gives the verdict. All prediction and comparison live in the checker.
module reed_solomon_ecc_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 30;

  // Byte addresses of the length register and of an address that holds no register.
  localparam logic [rse_pkg::ADDR_W-1:0] ECC_LENGTH_ADDR = {rse_pkg::REG_ECC_LENGTH, 2'b00};
  localparam logic [rse_pkg::ADDR_W-1:0] SPARE_ADDR      = {~rse_pkg::REG_ECC_LENGTH, 2'b00};

  // Data items in each random phase; the eight phases, the directed items and the
  // overrun of the last block of each phase give roughly 350 items.
  localparam int ITEMS_PER_PHASE = 36;
  localparam int RANDOM_PHASES   = 8;

  // A handful of spare cycles is ample for any item still inside the pipeline
  // before a register write.
  localparam int SETTLE_CYCLES = 6;

  // The slowest correct run has every item closing a block of thirty parity
  // items with the receiver mostly stalled; this limit is several times that.
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_LIGHT,
    DRAIN_HEAVY
  } drain_mode_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       psel      = 1'b0;
  logic                       penable   = 1'b0;
  logic                       pwrite    = 1'b0;
  logic [rse_pkg::ADDR_W-1:0] paddr     = '0;
  logic [31:0]                pwdata    = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [7:0]                 data_byte = 8'h00;
  logic                       block_end = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 ecc_byte;
  logic                       ecc_last;

  int pending;
  int mismatches;
  int cycles = 0;

  // Sender burst state: a burst of back-to-back items, then a gap, unless the
  // phase has been chosen to run steadily with no gaps at all.
  int burst_left = 0;
  bit steady     = 1'b0;

  // Receiver pattern state.
  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_left = 0;

  reed_solomon_ecc_encoder #(
    .MAX_ECC_LEN(MAX_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .data_byte(data_byte),
    .block_end(block_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ecc_byte (ecc_byte),
    .ecc_last (ecc_last)
  );

  rs_parity_checker #(
    .MAX_ECC_LEN(MAX_LEN)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .block_end (block_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ecc_byte  (ecc_byte),
    .ecc_last  (ecc_last),
    .pending   (pending),
    .mismatches(mismatches)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog. A hung handshake or a parity item that never arrives ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("reed_solomon_ecc_encoder_tb: errors");
      $finish;
    end
  end

  // The receiver switches between free-running, lightly stalled and heavily
  // stalled stretches of random length, so that stalls land on every parity
  // position, including the last of a block and the first of the next.
  always @(negedge clk) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 2));
      drain_left = $urandom_range(20, 200);
    end
    drain_left = drain_left - 1;
    case (drain_mode)
      DRAIN_FREE: begin
        out_stall <= 1'b0;
      end
      DRAIN_LIGHT: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Idle cycles on the data channel. The payload wanders while valid is low,
  // which the block must ignore.
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom);
      block_end <= 1'($urandom);
    end
  endtask

  // Presents one item and returns at the rising edge that accepts it. The
  // stall is read straight after the edge, so it is the value the block saw.
  task automatic push_byte(input logic [7:0] d, input logic is_end);
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= d;
    block_end <= is_end;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
  endtask

  task automatic send_data_byte(input logic [7:0] d, input logic is_end);
    if (burst_left == 0) begin
      if (!steady) begin
        hold_off($urandom_range(1, 6));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    push_byte(d, is_end);
  endtask

  // Brings the block to rest: valid low, every parity item delivered, and a
  // few more cycles for anything that produces no parity to leave the pipeline.
  task automatic settle();
    hold_off(1);
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; pready is tied high but is honoured anyway.
  task automatic write_reg(input logic [rse_pkg::ADDR_W-1:0] a, input logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) begin
      @(posedge clk);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [31:0] len_word;
    int          sent;
    int          blk;

    // Hold reset at the start. The block then rebuilds its generator while
    // stalling the input, which the handshake simply waits out.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Reset length of ten first: the byte extremes, then a
    // block made of a single item.
    steady = ($urandom_range(0, 1) == 0);
    send_data_byte(8'h00, 1'b0);
    send_data_byte(8'hFF, 1'b1);
    send_data_byte(8'h80, 1'b1);
    settle();

    // Shortest parity length.
    write_reg(ECC_LENGTH_ADDR, 32'd1);
    send_data_byte(8'h01, 1'b0);
    send_data_byte(8'hFE, 1'b1);
    settle();

    // A length of zero behaves as a length of one.
    write_reg(ECC_LENGTH_ADDR, 32'd0);
    send_data_byte(8'h55, 1'b1);
    settle();

    // Thirty-one saturates to the register depth.
    write_reg(ECC_LENGTH_ADDR, 32'd31);
    send_data_byte(8'hAA, 1'b0);
    send_data_byte(8'h00, 1'b1);
    settle();

    // The full depth, written directly.
    write_reg(ECC_LENGTH_ADDR, 32'd30);
    send_data_byte(8'h7F, 1'b0);
    send_data_byte(8'hC3, 1'b0);
    send_data_byte(8'h3C, 1'b1);
    settle();

    // A partial block is thrown away when the length is written mid-block.
    send_data_byte(8'h12, 1'b0);
    send_data_byte(8'h34, 1'b0);
    send_data_byte(8'h56, 1'b0);
    settle();
    write_reg(ECC_LENGTH_ADDR, 32'd5);
    send_data_byte(8'h9A, 1'b0);
    send_data_byte(8'hBC, 1'b1);
    settle();

    // A write to the empty address must leave everything untouched.
    write_reg(SPARE_ADDR, 32'd7);
    send_data_byte(8'hDE, 1'b0);
    send_data_byte(8'hAD, 1'b1);
    settle();

    // Only the low five bits of the written word count.
    write_reg(ECC_LENGTH_ADDR, 32'hFFFF_FFE3);
    send_data_byte(8'hF0, 1'b0);
    send_data_byte(8'h0F, 1'b1);
    settle();

    // Random part. The first four phases revisit the extreme lengths, the rest
    // draw any five-bit value under random upper bits. Blocks are mostly short,
    // with the odd long one of nine to forty items.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: len_word = 32'd1;
        1: len_word = 32'd30;
        2: len_word = 32'd0;
        3: len_word = 32'd31;
        default: len_word = $urandom;
      endcase
      write_reg(ECC_LENGTH_ADDR, len_word);
      if (ph == RANDOM_PHASES - 3) begin
        write_reg(SPARE_ADDR, $urandom);
      end
      steady = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        blk = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int k = 0; k < blk; k++) begin
          send_data_byte(8'($urandom_range(0, 255)), k == blk - 1);
          sent++;
        end
      end
      // One phase finishes on a half-sent block for the next write to drop.
      if (ph == RANDOM_PHASES - 2) begin
        blk = $urandom_range(1, 5);
        for (int k = 0; k < blk; k++) begin
          send_data_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      settle();
    end

    // Everything has been delivered; give the pipeline a little longer in
    // case a stray parity item follows.
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("reed_solomon_ecc_encoder_tb: clean");
    end else begin
      $display("reed_solomon_ecc_encoder_tb: errors");
    end
    $finish;
  end

endmodule
